// ----- rtl/pnds_pkg.sv -----
// Shared constants and types of the Pareto non-dominated sort unit.
package pnds_pkg;

    localparam int POP_SIZE  = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int OBJ_W     = 32;
    localparam int NUM_OBJ   = 5;
    localparam int OBJ_VEC_W = OBJ_W * NUM_OBJ;
    localparam int ACT_W     = 3;
    localparam int OUT_W     = 16;

    // objectives one, three and four are maximized
    localparam logic [NUM_OBJ-1:0] MAXIMIZE = 5'b01101;

    typedef struct packed {
        logic fwd;
        logic bwd;
    } dom_pair_t;

endpackage

// ----- rtl/pnds_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module pnds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/pnds_cmp.sv -----
// Two-way dominance test between two individuals.
module pnds_cmp (
    input  logic [pnds_pkg::OBJ_VEC_W-1:0] a,
    input  logic [pnds_pkg::OBJ_VEC_W-1:0] b,
    input  logic [pnds_pkg::ACT_W-1:0]     act,
    output pnds_pkg::dom_pair_t            res
);
    import pnds_pkg::*;

    logic [NUM_OBJ-1:0] a_better;
    logic [NUM_OBJ-1:0] a_worse;

    always_comb
    begin
        logic signed [OBJ_W-1:0] x;
        logic signed [OBJ_W-1:0] y;
        for (int k = 0; k < NUM_OBJ; k++)
        begin
            x = a[k*OBJ_W +: OBJ_W];
            y = b[k*OBJ_W +: OBJ_W];
            if (ACT_W'(k) < act)
            begin
                a_better[k] = MAXIMIZE[k] ? (x > y) : (x < y);
                a_worse[k]  = MAXIMIZE[k] ? (x < y) : (x > y);
            end
            else
            begin
                a_better[k] = 1'b0;
                a_worse[k]  = 1'b0;
            end
        end
        res.fwd = !(|a_worse) && (|a_better);
        res.bwd = !(|a_better) && (|a_worse);
    end

endmodule

// ----- rtl/pareto_nondominated_sort_unit.sv -----
// Loads up to 64 individuals at one item per cycle while idle; the item marked last starts
// the sort. With n individuals stored, building the dominance matrix takes one
// objective-store read per pair and peeling the fronts one count-memory read per
// matrix bit, written back where the bit is set. Results leave through an output
// register in front order while loading of the next population waits.
module pareto_nondominated_sort_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // damage_dealt, damage_taken, distance_travelled, tree_utilization, tree_size
    input  logic [pnds_pkg::OBJ_VEC_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // item_index, front_rank, zero pad
    output logic [pnds_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [pnds_pkg::ACT_W-1:0]      cfg_wdata
);
    import pnds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MROW, S_MLAT, S_MSCAN, S_MEND, S_MWR,
        S_FRD, S_FLAT, S_FEMIT, S_FSCAN, S_FEND, S_FNEXT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   n_reg, p_reg, q_reg, i_reg, cur_len_reg, next_len_reg, emit_reg;
    logic [CNT_W-1:0]   acc_reg;
    logic [IDX_W-1:0]   qd_reg, pcur_reg, rank_reg;
    logic               qv_reg, sel_reg;
    logic [OBJ_VEC_W-1:0] a_reg;
    logic [POP_SIZE-1:0] row_reg;
    logic [ACT_W-1:0]   act_reg;
    logic               out_valid_reg, out_last_reg;
    logic [IDX_W-1:0]   out_idx_reg, out_rank_reg;

    logic               in_acc;
    logic               obj_we;
    logic [IDX_W-1:0]   obj_raddr;
    logic [OBJ_VEC_W-1:0] obj_rdata;
    logic [IDX_W-1:0]   dom_raddr;
    logic [POP_SIZE-1:0] dom_rdata;
    logic               cnt_we;
    logic [IDX_W-1:0]   cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
    logic               cur_we, nxt_we;
    logic [IDX_W-1:0]   cur_waddr;
    logic [IDX_W-1:0]   la_rdata, lb_rdata, cur_rdata;
    logic               la_we, lb_we;
    logic [IDX_W-1:0]   la_waddr, lb_waddr, lst_wdata;
    logic               fr_upd, fr_dec, fr_zero;
    logic               m_upd, out_load;
    dom_pair_t          cmp_res;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign obj_we        = in_acc && (n_reg < CNT_W'(POP_SIZE));
    assign obj_raddr     = (state_reg == S_MROW) ? p_reg[IDX_W-1:0] : q_reg[IDX_W-1:0];
    assign dom_raddr     = (state_reg == S_FLAT) ? cur_rdata : pcur_reg;
    assign cur_rdata     = sel_reg ? lb_rdata : la_rdata;

    assign m_upd   = qv_reg && (state_reg == S_MSCAN || state_reg == S_MEND);
    assign fr_upd  = qv_reg && (state_reg == S_FSCAN || state_reg == S_FEND);
    assign fr_dec  = fr_upd && row_reg[qd_reg] && (cnt_rdata != '0);
    assign fr_zero = fr_dec && (cnt_rdata == CNT_W'(1)) && (next_len_reg < CNT_W'(POP_SIZE));
    assign out_load = (state_reg == S_FEMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = qd_reg;
        cnt_wdata = cnt_rdata - CNT_W'(1);
        if (state_reg == S_MWR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = p_reg[IDX_W-1:0];
            cnt_wdata = acc_reg;
        end
        else if (fr_dec)
        begin
            cnt_we = 1'b1;
        end
    end

    assign cur_we    = (state_reg == S_MWR) && (acc_reg == '0);
    assign cur_waddr = cur_len_reg[IDX_W-1:0];
    assign nxt_we    = fr_zero;
    assign lst_wdata = (state_reg == S_MWR) ? p_reg[IDX_W-1:0] : qd_reg;
    assign la_we     = sel_reg ? nxt_we : cur_we;
    assign lb_we     = sel_reg ? cur_we : nxt_we;
    assign la_waddr  = sel_reg ? next_len_reg[IDX_W-1:0] : cur_waddr;
    assign lb_waddr  = sel_reg ? cur_waddr : next_len_reg[IDX_W-1:0];

    pnds_ram #(.WIDTH(OBJ_VEC_W), .DEPTH(POP_SIZE)) u_obj (
        .clk(clk), .we(obj_we), .waddr(n_reg[IDX_W-1:0]), .wdata(s_axis_tdata),
        .raddr(obj_raddr), .rdata(obj_rdata)
    );

    pnds_ram #(.WIDTH(POP_SIZE), .DEPTH(POP_SIZE)) u_dom (
        .clk(clk), .we(state_reg == S_MWR), .waddr(p_reg[IDX_W-1:0]), .wdata(row_reg),
        .raddr(dom_raddr), .rdata(dom_rdata)
    );

    pnds_ram #(.WIDTH(CNT_W), .DEPTH(POP_SIZE)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(q_reg[IDX_W-1:0]), .rdata(cnt_rdata)
    );

    pnds_ram #(.WIDTH(IDX_W), .DEPTH(POP_SIZE)) u_list_a (
        .clk(clk), .we(la_we), .waddr(la_waddr), .wdata(lst_wdata),
        .raddr(i_reg[IDX_W-1:0]), .rdata(la_rdata)
    );

    pnds_ram #(.WIDTH(IDX_W), .DEPTH(POP_SIZE)) u_list_b (
        .clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lst_wdata),
        .raddr(i_reg[IDX_W-1:0]), .rdata(lb_rdata)
    );

    pnds_cmp u_cmp (
        .a(a_reg), .b(obj_rdata), .act(act_reg), .res(cmp_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            p_reg         <= '0;
            q_reg         <= '0;
            i_reg         <= '0;
            cur_len_reg   <= '0;
            next_len_reg  <= '0;
            emit_reg      <= '0;
            qv_reg        <= 1'b0;
            sel_reg       <= 1'b0;
            rank_reg      <= '0;
            act_reg       <= ACT_W'(NUM_OBJ);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                act_reg <= (cfg_wdata > ACT_W'(NUM_OBJ)) ? ACT_W'(NUM_OBJ) : cfg_wdata;
            end

            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            if (m_upd)
            begin
                row_reg[qd_reg] <= cmp_res.fwd;
                acc_reg         <= acc_reg + CNT_W'(cmp_res.bwd);
            end

            if (fr_zero)
            begin
                next_len_reg <= next_len_reg + CNT_W'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (obj_we)
                        begin
                            n_reg <= n_reg + CNT_W'(1);
                        end
                        if (s_axis_tlast)
                        begin
                            p_reg       <= '0;
                            cur_len_reg <= '0;
                            emit_reg    <= '0;
                            state_reg   <= S_MROW;
                        end
                    end
                end
                S_MROW:
                begin
                    row_reg   <= '0;
                    acc_reg   <= '0;
                    q_reg     <= '0;
                    state_reg <= S_MLAT;
                end
                S_MLAT:
                begin
                    a_reg  <= obj_rdata;
                    qv_reg <= 1'b1;
                    qd_reg <= '0;
                    q_reg  <= CNT_W'(1);
                    state_reg <= (n_reg == CNT_W'(1)) ? S_MEND : S_MSCAN;
                end
                S_MSCAN:
                begin
                    qv_reg <= 1'b1;
                    qd_reg <= q_reg[IDX_W-1:0];
                    q_reg  <= q_reg + CNT_W'(1);
                    if (q_reg == n_reg - CNT_W'(1))
                    begin
                        state_reg <= S_MEND;
                    end
                end
                S_MEND:
                begin
                    qv_reg    <= 1'b0;
                    state_reg <= S_MWR;
                end
                S_MWR:
                begin
                    if (acc_reg == '0)
                    begin
                        cur_len_reg <= cur_len_reg + CNT_W'(1);
                    end
                    p_reg <= p_reg + CNT_W'(1);
                    if (p_reg == n_reg - CNT_W'(1))
                    begin
                        i_reg        <= '0;
                        next_len_reg <= '0;
                        rank_reg     <= '0;
                        emit_reg     <= '0;
                        state_reg    <= S_FRD;
                    end
                    else
                    begin
                        state_reg <= S_MROW;
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FLAT;
                end
                S_FLAT:
                begin
                    pcur_reg  <= cur_rdata;
                    state_reg <= S_FEMIT;
                end
                S_FEMIT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= pcur_reg;
                        out_rank_reg  <= rank_reg;
                        out_last_reg  <= (emit_reg == n_reg - CNT_W'(1));
                        emit_reg      <= emit_reg + CNT_W'(1);
                        row_reg       <= dom_rdata;
                        q_reg         <= '0;
                        state_reg     <= S_FSCAN;
                    end
                end
                S_FSCAN:
                begin
                    qv_reg <= 1'b1;
                    qd_reg <= q_reg[IDX_W-1:0];
                    q_reg  <= q_reg + CNT_W'(1);
                    if (q_reg == n_reg - CNT_W'(1))
                    begin
                        state_reg <= S_FEND;
                    end
                end
                S_FEND:
                begin
                    qv_reg    <= 1'b0;
                    state_reg <= S_FNEXT;
                end
                S_FNEXT:
                begin
                    if (i_reg == cur_len_reg - CNT_W'(1))
                    begin
                        if (next_len_reg == '0)
                        begin
                            n_reg     <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            sel_reg      <= ~sel_reg;
                            cur_len_reg  <= next_len_reg;
                            next_len_reg <= '0;
                            rank_reg     <= rank_reg + IDX_W'(1);
                            i_reg        <= '0;
                            state_reg    <= S_FRD;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_FRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_W - 2*IDX_W)'(0), out_rank_reg, out_idx_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(POP_SIZE))
        else $error("population count past capacity");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> emit_reg <= n_reg)
        else $error("more results than individuals");

    a_next_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> next_len_reg <= n_reg)
        else $error("next front longer than population");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MWR |-> acc_reg < n_reg)
        else $error("domination count reaches population size");

endmodule
